// ===== sv/circle_span_rasterizer_core_assert.svh =====
// assertion macros for the circle span rasteriser
`ifndef CIRCLE_SPAN_RASTERIZER_CORE_ASSERT_SVH
`define CIRCLE_SPAN_RASTERIZER_CORE_ASSERT_SVH

`ifndef SYNTH
`define CSR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("circle span rasteriser: property failed");
`define CSR_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("circle span rasteriser: forbidden condition");
`else
`define CSR_ASSERT(lbl, prop)
`define CSR_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== sv/csrast_pkg.sv =====
`timescale 1ns / 1ps

package csrast_pkg;

  localparam int unsigned RADIUS_W = 10;
  localparam int unsigned SQ_W     = 20;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned PC_W     = 4;

  // input command and drawing mode codes
  localparam logic CMD_START    = 1'b0;
  localparam logic CMD_NEXT_ROW = 1'b1;
  localparam logic MODE_RING    = 1'b0;
  localparam logic MODE_DISK    = 1'b1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MUL_R,
    OP_MUL_RI,
    OP_IM2,
    OP_WALK_O,
    OP_WALK_I,
    OP_EMIT,
    OP_ADV
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_BAD,
    C_WALK_O,
    C_WALK_I,
    C_DISK,
    C_EMPTY,
    C_ROW0
  } cond_e;

  typedef enum logic [3:0] {
    EM_NONE,
    EM_Q0,
    EM_Q1,
    EM_Q2,
    EM_Q3,
    EM_DP,
    EM_DM,
    EM_NULL_ROW,
    EM_NULL_FIN
  } emit_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
    emit_e            emit;
    logic             last;
    logic             stop;
  } ucode_t;

  // program entry points and jump targets
  localparam logic [PC_W-1:0] PC_START    = 4'd0;
  localparam logic [PC_W-1:0] PC_ROW      = 4'd3;
  localparam logic [PC_W-1:0] PC_WALK_I   = 4'd5;
  localparam logic [PC_W-1:0] PC_DISK     = 4'd11;
  localparam logic [PC_W-1:0] PC_ADV      = 4'd13;
  localparam logic [PC_W-1:0] PC_NULL_FIN = 4'd14;
  localparam logic [PC_W-1:0] PC_NULL_ROW = 4'd15;

  function automatic ucode_t uword(input op_e op, input cond_e cond,
                                   input logic [PC_W-1:0] target, input emit_e emit,
                                   input logic last, input logic stop);
    ucode_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.emit   = emit;
    w.last   = last;
    w.stop   = stop;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      4'd0:  w = uword(OP_MUL_R,  C_BAD,    PC_NULL_FIN, EM_NONE,     1'b0, 1'b0);
      4'd1:  w = uword(OP_MUL_RI, C_NEXT,   PC_START,    EM_NONE,     1'b0, 1'b0);
      4'd2:  w = uword(OP_IM2,    C_NEXT,   PC_START,    EM_NONE,     1'b0, 1'b0);
      4'd3:  w = uword(OP_WALK_O, C_WALK_O, PC_ROW,      EM_NONE,     1'b0, 1'b0);
      4'd4:  w = uword(OP_NOP,    C_DISK,   PC_DISK,     EM_NONE,     1'b0, 1'b0);
      4'd5:  w = uword(OP_WALK_I, C_WALK_I, PC_WALK_I,   EM_NONE,     1'b0, 1'b0);
      4'd6:  w = uword(OP_NOP,    C_EMPTY,  PC_NULL_ROW, EM_NONE,     1'b0, 1'b0);
      4'd7:  w = uword(OP_EMIT,   C_NEXT,   PC_START,    EM_Q0,       1'b0, 1'b0);
      4'd8:  w = uword(OP_EMIT,   C_NEXT,   PC_START,    EM_Q1,       1'b0, 1'b0);
      4'd9:  w = uword(OP_EMIT,   C_NEXT,   PC_START,    EM_Q2,       1'b0, 1'b0);
      4'd10: w = uword(OP_EMIT,   C_JUMP,   PC_ADV,      EM_Q3,       1'b1, 1'b0);
      4'd11: w = uword(OP_EMIT,   C_ROW0,   PC_ADV,      EM_DP,       1'b0, 1'b0);
      4'd12: w = uword(OP_EMIT,   C_NEXT,   PC_START,    EM_DM,       1'b1, 1'b0);
      4'd13: w = uword(OP_ADV,    C_NEXT,   PC_START,    EM_NONE,     1'b0, 1'b1);
      4'd14: w = uword(OP_EMIT,   C_NEXT,   PC_START,    EM_NULL_FIN, 1'b1, 1'b1);
      4'd15: w = uword(OP_EMIT,   C_JUMP,   PC_ADV,      EM_NULL_ROW, 1'b1, 1'b0);
      default: w = uword(OP_NOP,  C_NEXT,   PC_START,    EM_NONE,     1'b0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

// ===== sv/circle_span_rasterizer_core.sv =====
`timescale 1ns / 1ps
// circle span rasteriser
// input stream: tuser is the command (0 start a circle and draw row 0, 1 draw the next row);
// tdata carries center_x, center_y, radius, thickness, fill_mode and ink_in from bit 0 up.
// output stream: one transfer per span, tdata holds span_x, span_y, span_len, ink_out,
// tuser holds has_span and finished, tlast marks the final span of an input item.
// an input item gives one to four output transfers; a row of a ring gives four spans (or one
// transfer with has_span low where the outer edge lies inside the inner edge), a row of a disk
// one or two, a bad start or a next-row command with no circle one transfer with has_span low.
// one item at a time runs through a 16-step microprogram. a start runs its setup (two
// squarings on the shared multiplier, then the inner-edge square step) before its row. a row
// walks the outer edge in, then for a ring the inner edge, emits its spans one by one and
// advances the row, and the input is ready again the cycle after the last step. a bad start
// or a next-row command with no circle registers its single transfer from the null-finish step.
// tready is low while the program runs; a span waits in the output register while the
// receiver stalls and the program holds on its emit step. the next item is taken as
// soon as the program ends, even while the last span is still waiting.
// reset clears the program counter, the output register and every circle register.
module circle_span_rasterizer_core
  import csrast_pkg::*;
#(
  parameter int unsigned COORD_BITS = 11
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // center_x, center_y, radius, thickness, fill_mode, ink_in, zero pad
  input  logic [((2*COORD_BITS+22)+7)/8*8-1:0]     s_axis_tdata_i,
  // cmd
  input  logic                                     s_axis_tuser_i,
  output logic                                     m_axis_tvalid_o,
  input  logic                                     m_axis_tready_i,
  // span_x, span_y, span_len, ink_out, zero pad
  output logic [((2*COORD_BITS+15)+7)/8*8-1:0]     m_axis_tdata_o,
  // has_span, finished
  output logic [1:0]                               m_axis_tuser_o,
  output logic                                     m_axis_tlast_o
);

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned OUT_DW = ((2*CB+15)+7)/8*8;
  localparam int unsigned XW     = CB + 1;
  localparam int unsigned YW     = CB + 2;
  localparam int unsigned EW     = ((CB > RADIUS_W) ? CB : RADIUS_W) + 2;

  // input fields
  logic                in_cmd;
  logic [CB-1:0]       in_cx;
  logic [CB-1:0]       in_cy;
  logic [RADIUS_W-1:0] in_r;
  logic [RADIUS_W-1:0] in_t;
  logic                in_mode;
  logic                in_ink;
  logic [RADIUS_W-1:0] in_ri;
  logic                in_accept;

  assign in_cmd  = s_axis_tuser_i;
  assign in_cx   = s_axis_tdata_i[CB-1:0];
  assign in_cy   = s_axis_tdata_i[2*CB-1:CB];
  assign in_r    = s_axis_tdata_i[2*CB+9:2*CB];
  assign in_t    = s_axis_tdata_i[2*CB+19:2*CB+10];
  assign in_mode = s_axis_tdata_i[2*CB+20];
  assign in_ink  = s_axis_tdata_i[2*CB+21];
  assign in_ri   = in_r - ((in_t < in_r) ? in_t : in_r);

  // sequencer
  logic            run_q, run_d;
  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          uc;

  // circle state
  logic [RADIUS_W-1:0] row_q, row_d;
  logic [SQ_W-1:0]     d2_q, d2_d;
  logic [RADIUS_W-1:0] outer_q, outer_d;
  logic [RADIUS_W-1:0] inner_q, inner_d;
  logic [SQ_W-1:0]     ox2_q, ox2_d;
  logic [SQ_W-1:0]     im2_q, im2_d;
  logic [SQ_W-1:0]     osq_q, osq_d;
  logic [SQ_W-1:0]     isq_q, isq_d;
  logic [CB-1:0]       cx_q, cx_d;
  logic [CB-1:0]       cy_q, cy_d;
  logic [RADIUS_W-1:0] radius_q, radius_d;
  logic                mode_q, mode_d;
  logic                ink_q, ink_d;
  logic                busy_q, busy_d;

  // output register
  logic             mval_q, mval_d;
  logic [XW-1:0]    ox_q, ox_d;
  logic [YW-1:0]    oy_q, oy_d;
  logic [LEN_W-1:0] olen_q, olen_d;
  logic             oink_q, oink_d;
  logic             ohas_q, ohas_d;
  logic             olast_q, olast_d;
  logic             ofin_q, ofin_d;

  // datapath
  logic [SQ_W:0]       sum_o, sum_i;
  logic                walk_o, walk_i, fin_row, cond_ok, slot_free, stall, step;
  logic [RADIUS_W-1:0] mul_a;
  logic [SQ_W-1:0]     prod;
  logic [EW-1:0]       cx_e, cy_e, d_e, xo_e, xi_e;
  logic [EW-1:0]       x_pi, x_mo, y_p, y_m;
  logic [LEN_W-1:0]    ring_len, disk_len;
  logic [EW-1:0]       em_x, em_y;
  logic [LEN_W-1:0]    em_len;
  logic                em_has, em_fin, em_last;

  assign uc        = ucode_rom(pc_q);
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !run_q;

  assign sum_o   = {1'b0, ox2_q} + {1'b0, d2_q};
  assign sum_i   = {1'b0, im2_q} + {1'b0, d2_q};
  assign walk_o  = (outer_q != '0) && (sum_o > {1'b0, osq_q});
  assign walk_i  = (inner_q != '0) && (sum_i >= {1'b0, isq_q});
  assign fin_row = row_q >= radius_q;

  assign mul_a = (uc.op == OP_MUL_RI) ? inner_q : radius_q;
  assign prod  = SQ_W'(mul_a) * SQ_W'(mul_a);

  assign cx_e = EW'(cx_q);
  assign cy_e = EW'(cy_q);
  assign d_e  = EW'(row_q);
  assign xo_e = EW'(outer_q);
  assign xi_e = EW'(inner_q);
  assign x_pi = cx_e + xi_e;
  assign x_mo = cx_e - xo_e;
  assign y_p  = cy_e + d_e;
  assign y_m  = cy_e - d_e;
  assign ring_len = LEN_W'(outer_q - inner_q) + LEN_W'(1);
  assign disk_len = {outer_q, 1'b1};

  assign slot_free = !mval_q || m_axis_tready_i;
  assign stall     = (uc.op == OP_EMIT) && !slot_free;
  assign step      = run_q && !stall;

  always_comb begin
    unique case (uc.cond)
      C_NEXT:   cond_ok = 1'b0;
      C_JUMP:   cond_ok = 1'b1;
      C_BAD:    cond_ok = !busy_q;
      C_WALK_O: cond_ok = walk_o;
      C_WALK_I: cond_ok = walk_i;
      C_DISK:   cond_ok = mode_q == MODE_DISK;
      C_EMPTY:  cond_ok = outer_q < inner_q;
      C_ROW0:   cond_ok = row_q == '0;
      default:  cond_ok = 1'b0;
    endcase
  end

  // span selection for the emit steps
  always_comb begin
    em_x   = '0;
    em_y   = '0;
    em_len = '0;
    em_has = 1'b1;
    em_fin = fin_row;
    unique case (uc.emit)
      EM_Q0: begin
        em_x = x_pi; em_y = y_p; em_len = ring_len;
      end
      EM_Q1: begin
        em_x = x_mo; em_y = y_p; em_len = ring_len;
      end
      EM_Q2: begin
        em_x = x_pi; em_y = y_m; em_len = ring_len;
      end
      EM_Q3: begin
        em_x = x_mo; em_y = y_m; em_len = ring_len;
      end
      EM_DP: begin
        em_x = x_mo; em_y = y_p; em_len = disk_len;
      end
      EM_DM: begin
        em_x = x_mo; em_y = y_m; em_len = disk_len;
      end
      EM_NULL_ROW: em_has = 1'b0;
      EM_NULL_FIN: begin
        em_has = 1'b0;
        em_fin = 1'b1;
      end
      default: em_has = 1'b0;
    endcase
    // row zero of a disk has a single span
    em_last = uc.last || ((uc.emit == EM_DP) && (row_q == '0));
  end

  // next state
  always_comb begin
    run_d    = run_q;
    pc_d     = pc_q;
    row_d    = row_q;
    d2_d     = d2_q;
    outer_d  = outer_q;
    inner_d  = inner_q;
    ox2_d    = ox2_q;
    im2_d    = im2_q;
    osq_d    = osq_q;
    isq_d    = isq_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    radius_d = radius_q;
    mode_d   = mode_q;
    ink_d    = ink_q;
    busy_d   = busy_q;
    mval_d   = mval_q && !m_axis_tready_i;
    ox_d     = ox_q;
    oy_d     = oy_q;
    olen_d   = olen_q;
    oink_d   = oink_q;
    ohas_d   = ohas_q;
    olast_d  = olast_q;
    ofin_d   = ofin_q;

    if (in_accept) begin
      run_d = 1'b1;
      if (in_cmd == CMD_START) begin
        pc_d     = PC_START;
        cx_d     = in_cx;
        cy_d     = in_cy;
        radius_d = in_r;
        mode_d   = in_mode;
        ink_d    = in_ink;
        row_d    = '0;
        d2_d     = '0;
        outer_d  = in_r;
        inner_d  = in_ri;
        busy_d   = !((in_r == '0) || ((in_mode == MODE_RING) && (in_t == '0)));
      end else begin
        pc_d = busy_q ? PC_ROW : PC_NULL_FIN;
      end
    end else if (step) begin
      pc_d = cond_ok ? uc.target : pc_q + PC_W'(1);
      if (uc.stop) begin
        run_d = 1'b0;
      end
      unique case (uc.op)
        OP_MUL_R: begin
          osq_d = prod;
          ox2_d = prod;
        end
        OP_MUL_RI: isq_d = prod;
        OP_IM2:    im2_d = isq_q - SQ_W'({inner_q, 1'b0}) + SQ_W'(1);
        OP_WALK_O: begin
          if (walk_o) begin
            // (x-1)^2 = x^2 - 2x + 1
            outer_d = outer_q - RADIUS_W'(1);
            ox2_d   = ox2_q - SQ_W'({outer_q, 1'b0}) + SQ_W'(1);
          end
        end
        OP_WALK_I: begin
          if (walk_i) begin
            // im2 holds (x-1)^2, step to (x-2)^2
            inner_d = inner_q - RADIUS_W'(1);
            im2_d   = im2_q - SQ_W'({inner_q, 1'b0}) + SQ_W'(3);
          end
        end
        OP_EMIT: begin
          mval_d  = 1'b1;
          ox_d    = em_x[XW-1:0];
          oy_d    = em_y[YW-1:0];
          olen_d  = em_len;
          oink_d  = ink_q;
          ohas_d  = em_has;
          olast_d = em_last;
          ofin_d  = em_fin;
        end
        OP_ADV: begin
          if (fin_row) begin
            busy_d = 1'b0;
          end else begin
            row_d = row_q + RADIUS_W'(1);
            d2_d  = d2_q + SQ_W'({row_q, 1'b1});
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      pc_q     <= PC_START;
      row_q    <= '0;
      d2_q     <= '0;
      outer_q  <= '0;
      inner_q  <= '0;
      ox2_q    <= '0;
      im2_q    <= '0;
      osq_q    <= '0;
      isq_q    <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      radius_q <= '0;
      mode_q   <= 1'b0;
      ink_q    <= 1'b0;
      busy_q   <= 1'b0;
      mval_q   <= 1'b0;
      ox_q     <= '0;
      oy_q     <= '0;
      olen_q   <= '0;
      oink_q   <= 1'b0;
      ohas_q   <= 1'b0;
      olast_q  <= 1'b0;
      ofin_q   <= 1'b0;
    end else begin
      run_q    <= run_d;
      pc_q     <= pc_d;
      row_q    <= row_d;
      d2_q     <= d2_d;
      outer_q  <= outer_d;
      inner_q  <= inner_d;
      ox2_q    <= ox2_d;
      im2_q    <= im2_d;
      osq_q    <= osq_d;
      isq_q    <= isq_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      radius_q <= radius_d;
      mode_q   <= mode_d;
      ink_q    <= ink_d;
      busy_q   <= busy_d;
      mval_q   <= mval_d;
      ox_q     <= ox_d;
      oy_q     <= oy_d;
      olen_q   <= olen_d;
      oink_q   <= oink_d;
      ohas_q   <= ohas_d;
      olast_q  <= olast_d;
      ofin_q   <= ofin_d;
    end
  end

  assign m_axis_tvalid_o = mval_q;
  assign m_axis_tdata_o  = OUT_DW'({oink_q, olen_q, oy_q, ox_q});
  assign m_axis_tuser_o  = {ofin_q, ohas_q};
  assign m_axis_tlast_o  = olast_q;

`include "circle_span_rasterizer_core_assert.svh"

  `CSR_ASSERT(a_outer_in_radius, busy_q |-> (outer_q <= radius_q))
  `CSR_ASSERT(a_inner_in_radius, busy_q |-> (inner_q <= radius_q))
  `CSR_ASSERT(a_row_in_radius, busy_q |-> (row_q <= radius_q))
  `CSR_ASSERT(a_outer_sq_track, (busy_q && run_q && (pc_q >= PC_ROW)) |-> (ox2_q == (SQ_W'(outer_q) * SQ_W'(outer_q))))
  `CSR_ASSERT_NEVER(a_null_not_last, mval_q && !olast_q && !ohas_q)

endmodule

// ===== dv/tb_circle_span_rasterizer_core.sv =====
`timescale 1ns / 1ps

module tb_circle_span_rasterizer_core
  import csrast_pkg::*;
();

  localparam int unsigned COORD_BITS = 11;
  localparam int unsigned IN_W       = ((2*COORD_BITS+22)+7)/8*8;
  localparam int unsigned OUT_W      = ((2*COORD_BITS+15)+7)/8*8;
  localparam int unsigned ITEM_GOAL  = 500;
  localparam int unsigned IDLE_LIMIT = 6000;
  localparam int unsigned LONG_HOLD  = 400;

  typedef struct packed {
    logic [11:0] x;
    logic [12:0] y;
    logic [10:0] len;
    logic        ink;
    logic        has;
    logic        fin;
    logic        last;
  } span_t;

  class span_scoreboard;
    span_t       pending_spans[$];
    span_t       row_spans[$];
    int unsigned errors;
    // copy of the circle registers
    int unsigned row_off, outer, inner, outer_sq, inner_sq, rad;
    int unsigned c_x, c_y;
    bit          disk, ink, busy;

    function new();
      errors  = 0;
      row_off = 0; outer = 0; inner = 0; outer_sq = 0; inner_sq = 0; rad = 0;
      c_x = 0; c_y = 0; disk = 0; ink = 0; busy = 0;
    endfunction

    function int unsigned pending();
      return pending_spans.size();
    endfunction

    function void add_span(int x, int y, int unsigned len, bit has);
      span_t s;
      s.x    = has ? 12'(x) : '0;
      s.y    = has ? 13'(y) : '0;
      s.len  = has ? 11'(len) : '0;
      s.ink  = ink;
      s.has  = has;
      s.fin  = 1'b0;
      s.last = 1'b0;
      row_spans.push_back(s);
    endfunction

    // walks the outer edge (and for a ring the inner edge) in for the current row offset and emits its spans
    function bit draw_row();
      int unsigned d, d2, len;
      int          cx, cy, dy, xo, xi;
      d  = row_off;
      d2 = d * d;
      cx = int'(c_x);
      cy = int'(c_y);
      dy = int'(d);
      while (outer > 0 && outer * outer + d2 > outer_sq) outer--;
      xo = int'(outer);
      if (disk == MODE_DISK) begin
        len = 2 * outer + 1;
        add_span(cx - xo, cy + dy, len, 1'b1);
        if (d != 0) add_span(cx - xo, cy - dy, len, 1'b1);
      end else begin
        while (inner > 0 && (inner - 1) * (inner - 1) + d2 >= inner_sq) inner--;
        xi = int'(inner);
        if (outer < inner) begin
          add_span(0, 0, 0, 1'b0);
        end else begin
          len = outer - inner + 1;
          add_span(cx + xi, cy + dy, len, 1'b1);
          add_span(cx - xo, cy + dy, len, 1'b1);
          add_span(cx + xi, cy - dy, len, 1'b1);
          add_span(cx - xo, cy - dy, len, 1'b1);
        end
      end
      if (d >= rad) begin
        busy = 1'b0;
        return 1'b1;
      end
      row_off = (d + 1) & 10'h3ff;
      return 1'b0;
    endfunction

    function void note_input(logic cmd, logic [IN_W-1:0] data);
      int unsigned r, t, stroke, ri;
      bit          fin;
      row_spans.delete();
      if (cmd == CMD_START) begin
        // cx [10:0], cy [21:11], radius [31:22], thickness [41:32], mode [42], ink [43]
        r        = data[31:22];
        t        = data[41:32];
        stroke   = (t < r) ? t : r;
        ri       = r - stroke;
        c_x      = data[10:0];
        c_y      = data[21:11];
        rad      = r;
        disk     = data[42];
        ink      = data[43];
        row_off  = 0;
        outer    = r;
        inner    = ri;
        outer_sq = r * r;
        inner_sq = ri * ri;
        if (r == 0 || (disk == MODE_RING && t == 0)) begin
          busy = 1'b0;
          add_span(0, 0, 0, 1'b0);
          fin = 1'b1;
        end else begin
          busy = 1'b1;
          fin  = draw_row();
        end
      end else if (!busy) begin
        add_span(0, 0, 0, 1'b0);
        fin = 1'b1;
      end else begin
        fin = draw_row();
      end
      foreach (row_spans[k]) begin
        row_spans[k].fin  = fin;
        row_spans[k].last = (k == row_spans.size() - 1);
        pending_spans.push_back(row_spans[k]);
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] data, logic [1:0] user, logic tlast);
      span_t want;
      if (pending_spans.size() == 0) begin
        $display("%0t: span with nothing expected, expected none, actual data %0h user %0h last %0b",
                 $time, data, user, tlast);
        errors++;
        return;
      end
      want = pending_spans.pop_front();
      compare_field("span_x",   want.x,    data[11:0]);
      compare_field("span_y",   want.y,    data[24:12]);
      compare_field("span_len", want.len,  data[35:25]);
      compare_field("ink_out",  want.ink,  data[36]);
      compare_field("has_span", want.has,  user[0]);
      compare_field("finished", want.fin,  user[1]);
      compare_field("last",     want.last, tlast);
    endfunction
  endclass

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [IN_W-1:0]  s_axis_tdata_i  = '0;
  logic             s_axis_tuser_i  = 1'b0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic [1:0]       m_axis_tuser_o;
  logic             m_axis_tlast_o;

  span_scoreboard span_book = new();
  int unsigned    items_sent   = 0;
  int unsigned    results_seen = 0;
  int unsigned    burst_left   = 0;

  circle_span_rasterizer_core #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [IN_W-1:0] pack_circle(logic [10:0] cx, logic [10:0] cy,
                                                  logic [9:0] r, logic [9:0] t,
                                                  logic mode, logic ink);
    logic [IN_W-1:0] data;
    data = IN_W'({ink, mode, t, r, cy, cx});
    return data;
  endfunction

  function automatic logic [IN_W-1:0] junk_data();
    logic [IN_W-1:0] data;
    data = IN_W'({$urandom, $urandom});
    data[IN_W-1:44] = '0;
    return data;
  endfunction

  // one transfer in, with bursts and random gaps between them
  task automatic send_item(logic cmd, logic [IN_W-1:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    span_book.note_input(cmd, data);
    items_sent++;
  endtask

  task automatic start_circle(logic [10:0] cx, logic [10:0] cy, logic [9:0] r,
                              logic [9:0] t, logic mode, logic ink, int unsigned rows);
    send_item(CMD_START, pack_circle(cx, cy, r, t, mode, ink));
    repeat (rows) send_item(CMD_NEXT_ROW, junk_data());
  endtask

  task automatic wait_drain();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (span_book.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_circle();
    int unsigned sel, r, rows;
    logic [9:0]  t;
    sel = $urandom_range(0, 99);
    if (sel < 6)       r = 0;
    else if (sel < 16) r = $urandom_range(0, 1023);
    else               r = $urandom_range(1, 14);
    sel = $urandom_range(0, 99);
    if (sel < 8)       t = '0;
    else if (sel < 30) t = 10'd1;
    else if (sel < 45) t = 10'($urandom_range(0, 1023));
    else               t = 10'($urandom_range(1, r + 2));
    if (r > 14)                          rows = $urandom_range(0, 6);
    else if ($urandom_range(0, 5) == 0)  rows = $urandom_range(0, r);  // cut short by a new start
    else                                 rows = r + $urandom_range(0, 2);
    start_circle(11'($urandom), 11'($urandom), 10'(r), t, 1'($urandom), 1'($urandom), rows);
  endtask

  // output side: stall pattern redrawn after each random stretch, one long hold-off
  initial begin
    int unsigned stall_kind, stretch, phase;
    bit          held;
    held  = 1'b0;
    phase = 0;
    forever begin
      stall_kind = $urandom_range(0, 3);
      stretch    = $urandom_range(8, 80);
      repeat (stretch) begin
        @(posedge clk_i);
        phase++;
        if (!held && results_seen >= 150) begin
          held = 1'b1;
          m_axis_tready_i <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk_i);
        end
        case (stall_kind)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= 1'($urandom);
          2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready_i <= (phase % 8) < 5;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      span_book.check_result(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      results_seen++;
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_circle_span_rasterizer_core: done, errors");
    $finish;
  end

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // next row with no circle, bad starts
    send_item(CMD_NEXT_ROW, junk_data());
    start_circle(11'd100, 11'd100, 10'd0, 10'd5, MODE_DISK, 1'b1, 0);
    start_circle(11'd100, 11'd100, 10'd7, 10'd0, MODE_RING, 1'b1, 0);
    // small disk run past its end, thickness ignored
    start_circle(11'd10, 11'd20, 10'd1, 10'd0, MODE_DISK, 1'b0, 2);
    // thick ring clipped to the radius, run to the end
    start_circle(11'd50, 11'd60, 10'd2, 10'h3ff, MODE_RING, 1'b1, 2);
    // extremes of the fields, dropped by the next start
    start_circle(11'h7ff, 11'h7ff, 10'h3ff, 10'h3ff, MODE_RING, 1'b1, 2);
    start_circle(11'd0, 11'd0, 10'h3ff, 10'd1, MODE_DISK, 1'b0, 2);
    start_circle(11'd0, 11'h7ff, 10'h3ff, 10'd1, MODE_RING, 1'b0, 2);
    // thin ring, rows where the outer edge can fall inside the inner edge
    start_circle(11'd3, 11'd1000, 10'd6, 10'd1, MODE_RING, 1'b1, 6);

    while (items_sent < ITEM_GOAL) begin
      if (!paused && items_sent >= ITEM_GOAL / 2) begin
        paused = 1'b1;
        wait_drain();
      end
      if ($urandom_range(0, 99) < 6)
        send_item(CMD_NEXT_ROW, junk_data());
      else
        random_circle();
    end
    s_axis_tvalid_i <= 1'b0;

    while (span_book.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (span_book.errors == 0 && span_book.pending() == 0) begin
      $display("tb_circle_span_rasterizer_core: done, clean");
    end else begin
      $display("tb_circle_span_rasterizer_core: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/csrast_pkg.sv
sv/circle_span_rasterizer_core.sv
dv/tb_circle_span_rasterizer_core.sv
